// ===== sv/w2s_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// w2s_pkg: shared types and constants for the world-to-screen projection
// Holds the payload words, the matrix and vector types, the sideband that
// travels beside the divider, and the fixed-point constants.
// ----------------------------------------------------------------------------
package w2s_pkg;

    localparam int COEF_W         = 16;
    localparam int COEF_FRAC_BITS = 12;
    localparam int DATA_W         = 32;
    localparam int REG_W          = 64;
    localparam int NUM_ROWS       = 4;
    localparam int CFG_ADDR_W     = 3;
    localparam int PROD_W         = COEF_W + DATA_W;
    localparam int ACC_W          = PROD_W + 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] CFG_VIEW_ROW0 = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_VIEW_ROW3 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PROJ_ROW0 = 3'd4;

    // Coefficient value 1.0 in Q4.12.
    localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [ACC_W-1:0]  ACC_ROUND = ACC_W'(1) << (COEF_FRAC_BITS - 1);

    typedef logic signed [DATA_W-1:0] s32_t;
    typedef s32_t [NUM_ROWS-1:0] vec4_t;
    typedef logic [NUM_ROWS-1:0][REG_W-1:0] mat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] pos_z;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] screen_x;
        logic signed [DATA_W-1:0] screen_y;
        logic signed [DATA_W-1:0] depth;
        logic                     behind_camera;
        logic                     overflow;
    } out_word_t;

    // Status that rides beside the divider.
    typedef struct packed {
        logic signed [DATA_W-1:0] depth;
        logic                     behind;
        logic                     w_zero;
        logic                     ovf;
        logic                     neg_x;
        logic                     neg_y;
    } side_t;

endpackage
`default_nettype wire

// ===== sv/w2s_matvec.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// w2s_matvec: two-stage 4x4 matrix by vector product
// Stage one forms the sixteen coefficient products, stage two sums each row,
// rounds half up, drops the coefficient fraction and saturates to 32 bits.
// ----------------------------------------------------------------------------
module w2s_matvec (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire w2s_pkg::vec4_t in_vec,
    input  wire logic           in_ov,
    input  wire w2s_pkg::mat_t  rows,
    output logic                out_valid,
    output w2s_pkg::vec4_t      out_vec,
    output logic                out_ov
);
    import w2s_pkg::*;

    logic signed [PROD_W-1:0] prod_next [NUM_ROWS][NUM_ROWS];
    logic signed [PROD_W-1:0] prod_reg  [NUM_ROWS][NUM_ROWS];
    logic                     valid_a_reg;
    logic                     ov_a_reg;
    logic                     valid_b_reg;
    vec4_t                    vec_b_reg;
    vec4_t                    vec_b_next;
    logic                     ov_b_reg;
    logic                     ov_b_next;

    // Sixteen products, one multiplier each.
    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int c = 0; c < NUM_ROWS; c++) begin
                prod_next[r][c] = PROD_W'($signed(rows[r][c*COEF_W +: COEF_W])
                                          * $signed(in_vec[c]));
            end
        end
    end

    // Row sums with rounding, fraction drop and saturation.
    always_comb begin
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] shifted;
        ov_b_next = ov_a_reg;
        for (int r = 0; r < NUM_ROWS; r++) begin
            acc = ACC_ROUND;
            for (int c = 0; c < NUM_ROWS; c++) begin
                acc = acc + ACC_W'(prod_reg[r][c]);
            end
            shifted = acc >>> COEF_FRAC_BITS;
            if (shifted > ACC_W'(S32_MAX)) begin
                vec_b_next[r] = S32_MAX;
                ov_b_next     = 1'b1;
            end else if (shifted < ACC_W'(S32_MIN)) begin
                vec_b_next[r] = S32_MIN;
                ov_b_next     = 1'b1;
            end else begin
                vec_b_next[r] = shifted[DATA_W-1:0];
            end
        end
    end

    // Valid bits follow the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else if (en) begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= prod_next;
            ov_a_reg  <= in_ov;
            vec_b_reg <= vec_b_next;
            ov_b_reg  <= ov_b_next;
        end
    end

    assign out_valid = valid_b_reg;
    assign out_vec   = vec_b_reg;
    assign out_ov    = ov_b_reg;

endmodule
`default_nettype wire

// ===== sv/w2s_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// w2s_div: pipelined unsigned restoring divider, two quotients per item
// One quotient bit per stage for x and y against a shared divisor; the
// status word rides along so it leaves together with the quotients.
// ----------------------------------------------------------------------------
module w2s_div #(
    parameter int POS_FRAC_BITS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              en,
    input  wire logic                              in_valid,
    input  wire logic [w2s_pkg::DATA_W+POS_FRAC_BITS-1:0] in_nx,
    input  wire logic [w2s_pkg::DATA_W+POS_FRAC_BITS-1:0] in_ny,
    input  wire logic [w2s_pkg::DATA_W-1:0]        in_d,
    input  wire w2s_pkg::side_t                    in_side,
    output logic                                   out_valid,
    output logic [w2s_pkg::DATA_W+POS_FRAC_BITS-1:0] out_qx,
    output logic [w2s_pkg::DATA_W+POS_FRAC_BITS-1:0] out_qy,
    output w2s_pkg::side_t                         out_side
);
    import w2s_pkg::*;

    localparam int NW = DATA_W + POS_FRAC_BITS;

    logic [NW-1:0]     nqx_lv  [NW+1];
    logic [NW-1:0]     nqy_lv  [NW+1];
    logic [DATA_W-1:0] remx_lv [NW+1];
    logic [DATA_W-1:0] remy_lv [NW+1];
    logic [DATA_W-1:0] d_lv    [NW+1];
    side_t             side_lv [NW+1];
    logic              vld_lv  [NW+1];

    assign nqx_lv[0]  = in_nx;
    assign nqy_lv[0]  = in_ny;
    assign remx_lv[0] = '0;
    assign remy_lv[0] = '0;
    assign d_lv[0]    = in_d;
    assign side_lv[0] = in_side;
    assign vld_lv[0]  = in_valid;

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DATA_W:0] shx;
        logic [DATA_W:0] shy;
        logic            gex;
        logic            gey;

        // Bring down the next dividend bit and try the subtraction.
        always_comb begin
            shx = {remx_lv[k], nqx_lv[k][NW-1]};
            shy = {remy_lv[k], nqy_lv[k][NW-1]};
            gex = shx >= {1'b0, d_lv[k]};
            gey = shy >= {1'b0, d_lv[k]};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_lv[k+1] <= 1'b0;
            end else if (en) begin
                vld_lv[k+1] <= vld_lv[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                remx_lv[k+1] <= gex ? DATA_W'(shx - {1'b0, d_lv[k]}) : shx[DATA_W-1:0];
                remy_lv[k+1] <= gey ? DATA_W'(shy - {1'b0, d_lv[k]}) : shy[DATA_W-1:0];
                nqx_lv[k+1]  <= {nqx_lv[k][NW-2:0], gex};
                nqy_lv[k+1]  <= {nqy_lv[k][NW-2:0], gey};
                d_lv[k+1]    <= d_lv[k];
                side_lv[k+1] <= side_lv[k];
            end
        end
    end

    assign out_valid = vld_lv[NW];
    assign out_qx    = nqx_lv[NW];
    assign out_qy    = nqy_lv[NW];
    assign out_side  = side_lv[NW];

endmodule
`default_nettype wire

// ===== sv/world_to_screen_projection.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// world_to_screen_projection: fixed-point world-to-screen transform
// Each input word is a world point (x, y, z) in signed Q16.16. It is carried
// through the view matrix and the projection matrix, whose rows are written
// on the cfg port (index 0..3 view rows, 4..7 projection rows, Q4.12 each).
// The result word holds normalized screen x and y, clip depth, a behind-camera
// flag and an overflow flag.
// Channels: s_valid/s_ready/s_data in, m_valid/m_ready/m_data out.
// The pipeline runs through both matrix units, the divider setup register, the
// restoring divider that retires one quotient bit per stage, and the output
// register. One word is accepted every cycle while the output is taken.
// When the receiver stalls, the whole pipeline holds and s_ready drops; no
// word is lost or repeated. Reset empties the pipeline and loads identity
// matrices into both sets of row registers.
// Write the cfg registers only while no word is in flight.
// ----------------------------------------------------------------------------
module world_to_screen_projection #(
    parameter int POS_FRAC_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire w2s_pkg::in_word_t             s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output w2s_pkg::out_word_t                 m_data,
    input  wire logic                          cfg_wr_en,
    input  wire logic [w2s_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [w2s_pkg::REG_W-1:0]     cfg_wdata
);
    import w2s_pkg::*;

    localparam int NW = DATA_W + POS_FRAC_BITS;
    localparam int EW = NW + 3;
    localparam logic signed [DATA_W-1:0] POS_ONE = DATA_W'(1) << POS_FRAC_BITS;
    localparam logic signed [EW-1:0]     ONE_E   = EW'(1) << POS_FRAC_BITS;

    logic      adv;
    mat_t      view_reg;
    mat_t      proj_reg;
    vec4_t     world_vec;
    logic      eye_valid;
    vec4_t     eye_vec;
    logic      eye_ov;
    logic      clip_valid;
    vec4_t     clip_vec;
    logic      clip_ov;
    logic      setup_valid_reg;
    logic [NW-1:0]     nx_reg;
    logic [NW-1:0]     ny_reg;
    logic [DATA_W-1:0] d_reg;
    side_t     side_reg;
    side_t     side_next;
    logic [DATA_W-1:0] ax;
    logic [DATA_W-1:0] ay;
    logic      div_valid;
    logic [NW-1:0] qx;
    logic [NW-1:0] qy;
    side_t     div_side;
    out_word_t out_next;
    logic      m_valid_reg;
    out_word_t m_data_reg;

    // The pipeline moves whenever the output register is free or drained.
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // Matrix row registers, identity after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_ROWS; i++) begin
                view_reg[i] <= REG_W'(COEF_ONE) << (COEF_W * i);
                proj_reg[i] <= REG_W'(COEF_ONE) << (COEF_W * i);
            end
        end else if (cfg_wr_en) begin
            if (cfg_addr <= CFG_VIEW_ROW3) begin
                view_reg[cfg_addr[1:0]] <= cfg_wdata;
            end else if (cfg_addr >= CFG_PROJ_ROW0) begin
                proj_reg[2'(cfg_addr - CFG_PROJ_ROW0)] <= cfg_wdata;
            end
        end
    end

    // World point in homogeneous form with w = 1.0.
    assign world_vec[0] = s_data.pos_x;
    assign world_vec[1] = s_data.pos_y;
    assign world_vec[2] = s_data.pos_z;
    assign world_vec[3] = POS_ONE;

    w2s_matvec u_view (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_valid),
        .in_vec    (world_vec),
        .in_ov     (1'b0),
        .rows      (view_reg),
        .out_valid (eye_valid),
        .out_vec   (eye_vec),
        .out_ov    (eye_ov)
    );

    w2s_matvec u_proj (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (eye_valid),
        .in_vec    (eye_vec),
        .in_ov     (eye_ov),
        .rows      (proj_reg),
        .out_valid (clip_valid),
        .out_vec   (clip_vec),
        .out_ov    (clip_ov)
    );

    // Divider setup: magnitudes, signs and the special cases of clip w.
    always_comb begin
        ax = clip_vec[0][DATA_W-1] ? DATA_W'(-clip_vec[0]) : clip_vec[0];
        ay = clip_vec[1][DATA_W-1] ? DATA_W'(-clip_vec[1]) : clip_vec[1];
        side_next.depth  = clip_vec[2];
        side_next.behind = clip_vec[3][DATA_W-1];
        side_next.w_zero = clip_vec[3] == '0;
        side_next.ovf    = clip_ov;
        side_next.neg_x  = clip_vec[0][DATA_W-1];
        side_next.neg_y  = clip_vec[1][DATA_W-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setup_valid_reg <= 1'b0;
        end else if (adv) begin
            setup_valid_reg <= clip_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nx_reg   <= {ax, POS_FRAC_BITS'(0)};
            ny_reg   <= {ay, POS_FRAC_BITS'(0)};
            d_reg    <= clip_vec[3];
            side_reg <= side_next;
        end
    end

    w2s_div #(
        .POS_FRAC_BITS (POS_FRAC_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (setup_valid_reg),
        .in_nx     (nx_reg),
        .in_ny     (ny_reg),
        .in_d      (d_reg),
        .in_side   (side_reg),
        .out_valid (div_valid),
        .out_qx    (qx),
        .out_qy    (qy),
        .out_side  (div_side)
    );

    // Signed quotients, screen mapping and final saturation.
    always_comb begin
        logic signed [EW-1:0] qx_s;
        logic signed [EW-1:0] qy_s;
        logic signed [EW-1:0] sx_full;
        logic signed [EW-1:0] sy_full;
        logic                 ov;
        qx_s    = div_side.neg_x ? -$signed({3'b000, qx}) : $signed({3'b000, qx});
        qy_s    = div_side.neg_y ? -$signed({3'b000, qy}) : $signed({3'b000, qy});
        sx_full = (qx_s + ONE_E) >>> 1;
        sy_full = ONE_E - ((qy_s + ONE_E) >>> 1);
        ov      = div_side.ovf;
        out_next.behind_camera = 1'b0;
        out_next.depth         = div_side.depth;
        if (sx_full > EW'(S32_MAX)) begin
            out_next.screen_x = S32_MAX;
            ov                = 1'b1;
        end else if (sx_full < EW'(S32_MIN)) begin
            out_next.screen_x = S32_MIN;
            ov                = 1'b1;
        end else begin
            out_next.screen_x = sx_full[DATA_W-1:0];
        end
        if (sy_full > EW'(S32_MAX)) begin
            out_next.screen_y = S32_MAX;
            ov                = 1'b1;
        end else if (sy_full < EW'(S32_MIN)) begin
            out_next.screen_y = S32_MIN;
            ov                = 1'b1;
        end else begin
            out_next.screen_y = sy_full[DATA_W-1:0];
        end
        out_next.overflow = ov;
        if (div_side.behind) begin
            // Behind the camera every value field is cleared.
            out_next.screen_x      = '0;
            out_next.screen_y      = '0;
            out_next.depth         = '0;
            out_next.behind_camera = 1'b1;
            out_next.overflow      = 1'b0;
        end else if (div_side.w_zero) begin
            // Zero w saturates x toward the sign of its numerator and y away from it.
            out_next.screen_x = div_side.neg_x ? S32_MIN : S32_MAX;
            out_next.screen_y = div_side.neg_y ? S32_MAX : S32_MIN;
            out_next.overflow = 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// ===== sv/w2s_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// w2s_checker: port-level checks for the world-to-screen projection
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module w2s_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire w2s_pkg::out_word_t m_data
);
    import w2s_pkg::*;

    // The output is empty in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output word present after reset");

    // A stalled output word holds.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled output word changed");

    // A stalled output backs up to the input side.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while output stalled");

    // A point behind the camera carries only its flag.
    a_behind_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.behind_camera |->
            m_data.screen_x == '0 && m_data.screen_y == '0 &&
            m_data.depth == '0 && !m_data.overflow)
        else $error("behind-camera word has nonzero fields");

endmodule

bind world_to_screen_projection w2s_checker u_w2s_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire

// ===== bench/projection_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// projection_checker: result predictor and scoreboard for the projection block
// Snoops the row register writes and both channels. Every accepted point is
// projected through its own copy of the view and projection matrices, and the
// screen word it yields is queued. Each result word leaving the block is
// compared field by field with the oldest queued word.
// ----------------------------------------------------------------------------
module projection_checker #(
    parameter int POS_FRAC = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  w2s_pkg::in_word_t              s_data,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  w2s_pkg::out_word_t             m_data,
    input  logic                           cfg_wr_en,
    input  logic [w2s_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [w2s_pkg::REG_W-1:0]      cfg_wdata,
    output int                             fail_count,
    output int                             pending,
    output int                             words_checked
);
    import w2s_pkg::*;

    localparam longint ONE = longint'(1) << POS_FRAC;
    localparam longint MAXV = 64'sd2147483647;
    localparam longint MINV = -64'sd2147483648;

    logic [REG_W-1:0] view_rows [NUM_ROWS];
    logic [REG_W-1:0] proj_rows [NUM_ROWS];
    out_word_t        screen_q [$];

    function automatic longint clamp32(input longint v, inout bit ovf);
        if (v > MAXV) begin
            ovf = 1'b1;
            return MAXV;
        end
        if (v < MINV) begin
            ovf = 1'b1;
            return MINV;
        end
        return v;
    endfunction

    // One row of a matrix times a vector, rounded half up and clamped.
    function automatic longint row_dot(input logic [REG_W-1:0] row, input longint v0,
                                       input longint v1, input longint v2,
                                       input longint v3, inout bit ovf);
        longint acc;
        acc = longint'($signed(row[15:0])) * v0 + longint'($signed(row[31:16])) * v1
            + longint'($signed(row[47:32])) * v2 + longint'($signed(row[63:48])) * v3;
        acc = (acc + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
        return clamp32(acc, ovf);
    endfunction

    function automatic out_word_t project(input in_word_t pt);
        longint    eye [NUM_ROWS];
        longint    clip [NUM_ROWS];
        longint    qx, qy;
        bit        ovf;
        out_word_t res;
        ovf = 1'b0;
        for (int r = 0; r < NUM_ROWS; r++)
            eye[r] = row_dot(view_rows[r], longint'(pt.pos_x), longint'(pt.pos_y),
                             longint'(pt.pos_z), ONE, ovf);
        for (int r = 0; r < NUM_ROWS; r++)
            clip[r] = row_dot(proj_rows[r], eye[0], eye[1], eye[2], eye[3], ovf);
        res = '0;
        // Behind the camera every value and the overflow flag are cleared.
        if (clip[3] < 0) begin
            res.behind_camera = 1'b1;
            return res;
        end
        res.depth = clip[2][31:0];
        if (clip[3] == 0) begin
            // Division by zero saturates x toward the sign of its numerator, y away from it.
            res.screen_x = (clip[0] >= 0) ? S32_MAX : S32_MIN;
            res.screen_y = (clip[1] >= 0) ? S32_MIN : S32_MAX;
            ovf = 1'b1;
        end else begin
            qx = (clip[0] * ONE) / clip[3];
            qy = (clip[1] * ONE) / clip[3];
            res.screen_x = 32'(clamp32((qx + ONE) >>> 1, ovf));
            res.screen_y = 32'(clamp32(ONE - ((qy + ONE) >>> 1), ovf));
        end
        res.overflow = ovf;
        return res;
    endfunction

    initial begin
        fail_count    = 0;
        pending       = 0;
        words_checked = 0;
    end

    // Track register writes and both handshakes at each rising edge.
    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_ROWS; i++) begin
                view_rows[i] = REG_W'(COEF_ONE) << (COEF_W * i);
                proj_rows[i] = REG_W'(COEF_ONE) << (COEF_W * i);
            end
            screen_q.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr <= CFG_VIEW_ROW3)
                    view_rows[2'(cfg_addr - CFG_VIEW_ROW0)] = cfg_wdata;
                else
                    proj_rows[2'(cfg_addr - CFG_PROJ_ROW0)] = cfg_wdata;
            end
            if (s_valid && s_ready)
                screen_q.push_back(project(s_data));
            if (m_valid && m_ready) begin
                if (screen_q.size() == 0) begin
                    $error("Result word arrived with nothing expected");
                    fail_count++;
                end else begin
                    want = screen_q.pop_front();
                    words_checked++;
                    if (m_data.screen_x !== want.screen_x) begin
                        $error("screen_x: expected %0d, got %0d", want.screen_x,
                               m_data.screen_x);
                        fail_count++;
                    end
                    if (m_data.screen_y !== want.screen_y) begin
                        $error("screen_y: expected %0d, got %0d", want.screen_y,
                               m_data.screen_y);
                        fail_count++;
                    end
                    if (m_data.depth !== want.depth) begin
                        $error("depth: expected %0d, got %0d", want.depth, m_data.depth);
                        fail_count++;
                    end
                    if (m_data.behind_camera !== want.behind_camera) begin
                        $error("behind_camera: expected %0b, got %0b",
                               want.behind_camera, m_data.behind_camera);
                        fail_count++;
                    end
                    if (m_data.overflow !== want.overflow) begin
                        $error("overflow: expected %0b, got %0b", want.overflow,
                               m_data.overflow);
                        fail_count++;
                    end
                end
            end
        end
        pending = screen_q.size();
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the world-to-screen projection block
// Runs a directed set of points through the identity matrices, then several
// matrix settings (camera-like perspective, random rows, extreme rows) with
// random points, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
    import w2s_pkg::*;

    localparam int POS_FRAC = 16;
    localparam int RUN_ITEMS = 280;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_word_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_word_t             m_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [REG_W-1:0]      cfg_wdata = '0;

    int fail_count, pending, words_checked;
    int points_sent = 0;
    int stall_left = 0;
    bit no_idle = 1'b0;
    logic [REG_W-1:0] rows [2*NUM_ROWS];

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    world_to_screen_projection #(.POS_FRAC_BITS(POS_FRAC)) dut (.*);

    projection_checker #(.POS_FRAC(POS_FRAC)) checker_i (.*);

    // Receiver: a random stall before each result word.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                stall_left = no_idle ? 0 : $urandom_range(0, 3);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_point(input in_word_t pt);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= pt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        points_sent++;
    endtask

    // Drain the pipeline, then load all eight row registers.
    task automatic load_rows();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        for (int i = 0; i < 2 * NUM_ROWS; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= CFG_ADDR_W'(i);
            cfg_wdata <= rows[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [REG_W-1:0] pack_row(input logic [15:0] c0, input logic [15:0] c1,
                                                  input logic [15:0] c2, input logic [15:0] c3);
        return {c3, c2, c1, c0};
    endfunction

    // Points are either full range or within eight units of the origin.
    function automatic logic signed [31:0] rand_coord(input bit near);
        if (near)
            return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
        return $urandom;
    endfunction

    task automatic run_points(input int count, input bit mostly_near);
        in_word_t pt;
        for (int n = 0; n < count; n++) begin
            if (n % 60 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            pt.pos_x = rand_coord(mostly_near && $urandom_range(0, 7) != 0);
            pt.pos_y = rand_coord(mostly_near && $urandom_range(0, 7) != 0);
            pt.pos_z = rand_coord(mostly_near && $urandom_range(0, 7) != 0);
            send_point(pt);
        end
    endtask

    task automatic set_rows_to(input logic [15:0] c);
        for (int i = 0; i < 2 * NUM_ROWS; i++)
            rows[i] = {c, c, c, c};
    endtask

    initial begin
        logic signed [31:0] corner [6];
        in_word_t pt;
        corner = '{32'sh0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000,
                   -32'sh0001_0000, 32'sh0000_8000};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corners through the reset identity matrices.
        for (int i = 0; i < 6; i++) begin
            pt = '{corner[i], corner[(i + 1) % 6], corner[(i + 3) % 6]};
            send_point(pt);
            pt = '{corner[i], corner[i], corner[i]};
            send_point(pt);
        end
        run_points(RUN_ITEMS, 1'b1);

        // Camera: view translates, projection puts -z into w.
        for (int i = 0; i < NUM_ROWS; i++)
            rows[i] = (REG_W'(COEF_ONE) << (COEF_W * i))
                    | (REG_W'($urandom_range(0, 16'h3FFF)) << 48);
        rows[NUM_ROWS + 0] = pack_row(16'h1000, 16'h0, 16'h0, 16'h0);
        rows[NUM_ROWS + 1] = pack_row(16'h0, 16'h1000, 16'h0, 16'h0);
        rows[NUM_ROWS + 2] = pack_row(16'h0, 16'h0, 16'hF000, 16'hE000);
        rows[NUM_ROWS + 3] = pack_row(16'h0, 16'h0, 16'hF000, 16'h0);
        rows[3] = pack_row(16'h0, 16'h0, 16'h0, 16'h1000);
        load_rows();
        // In front, at world z = 0 (zero w only if the z translation is zero) and behind the camera.
        send_point('{32'sh0002_0000, -32'sh0001_0000, -32'sh0004_0000});
        send_point('{32'sh0002_0000, -32'sh0001_0000, 32'sh0});
        send_point('{-32'sh0002_0000, 32'sh0001_0000, 32'sh0});
        send_point('{32'sh0002_0000, 32'sh0001_0000, 32'sh0004_0000});
        run_points(RUN_ITEMS, 1'b1);

        // Fully random rows, twice.
        for (int k = 0; k < 2; k++) begin
            foreach (rows[i]) rows[i] = {$urandom, $urandom};
            load_rows();
            run_points(RUN_ITEMS, k == 0);
        end

        // Extreme coefficients: all most positive, all most negative, all zero.
        set_rows_to(16'h7FFF);
        load_rows();
        run_points(RUN_ITEMS / 2, 1'b0);
        set_rows_to(16'h8000);
        load_rows();
        run_points(RUN_ITEMS / 2, 1'b1);
        set_rows_to(16'h0000);
        load_rows();
        run_points(RUN_ITEMS / 2, 1'b0);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);

        $display("Sent %0d points, checked %0d result words over 7 matrix settings,",
                 points_sent, words_checked);
        $display("including identity, perspective, random and extreme rows.");
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #400000;
        $display("Verification failed");
        $finish;
    end

endmodule
